// ===== rtl/core/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and codes for the inform retry table: request and result
// codes, the stored entry layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqAck    = 2'd1;
  localparam logic [1:0] ReqCancel = 2'd2;
  localparam logic [1:0] ReqTick   = 2'd3;

  localparam logic [2:0] KindPlain  = 3'd0;
  localparam logic [2:0] KindInform = 3'd1;
  localparam logic [2:0] KindResend = 3'd2;
  localparam logic [2:0] KindRetire = 3'd3;
  localparam logic [2:0] KindReject = 3'd4;
  localparam logic [2:0] KindDone   = 3'd5;

  typedef struct packed {
    logic [31:0] request_id;
    logic [7:0]  trap;
    logic [31:0] ip;
    logic [7:0]  retries;
    logic [23:0] timeout;
    logic [31:0] last_sent;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic final_step;
    logic flush;
  } irt_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_end;
  } irt_status_t;

endpackage

// ===== rtl/core/irt_ctrl.sv =====
// ----------------------------------------------------------------------------
// irt_ctrl
// Sequencer for one item: accept, table scan and drain when needed, final step, flush.
// ----------------------------------------------------------------------------
module irt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  irt_pkg::irt_status_t status_i,
  output irt_pkg::irt_cmd_t    cmd_o
);
  import irt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.scan_needed ? StScan : StFinal;
        end
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_end) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinal;
      end
      StFinal: begin
        cmd_o.final_step = 1'b1;
        state_d          = StFlush;
      end
      StFlush: begin
        cmd_o.flush = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |=> cmd_o.final_step)
    else $error("drain not followed by final step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.final_step |=> cmd_o.flush)
    else $error("final step not followed by flush");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |=> !busy_o)
    else $error("busy after flush");

endmodule

// ===== rtl/core/irt_datapath.sv =====
// ----------------------------------------------------------------------------
// irt_datapath
// Entry table, scan pipeline, result staging and output register.
// ----------------------------------------------------------------------------
module irt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irt_pkg::irt_cmd_t    cmd_i,
  output irt_pkg::irt_status_t status_o,
  input  logic [1:0]           req_type_i,
  input  logic [31:0]          request_id_i,
  input  logic [7:0]           trap_handle_i,
  input  logic [31:0]          dest_ip_i,
  input  logic                 build_ok_i,
  input  logic                 is_inform_i,
  input  logic                 replace_queued_i,
  input  logic [7:0]           retry_count_i,
  input  logic [23:0]          timeout_ms_i,
  input  logic [31:0]          now_ms_i,
  output logic                 result_valid_o,
  output logic [2:0]           result_kind_o,
  output logic [31:0]          out_request_id_o,
  output logic [7:0]           out_trap_handle_o,
  output logic [31:0]          out_ip_o,
  output logic                 last_o
);
  import irt_pkg::*;

  // latched item
  logic [1:0]  type_q;
  logic [31:0] rid_q;
  logic [7:0]  trap_q;
  logic [31:0] ip_q;
  logic        build_ok_q;
  logic        inform_q;
  logic [7:0]  retries_q;
  logic [23:0] timeout_q;
  logic [31:0] now_q;

  // table
  entry_t                mem [TableDepth];
  logic [TableDepth-1:0] valid_q;
  logic [IdxW-1:0]       scan_idx_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  rd_vld_q;
  entry_t                rd_data_q;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  entry_t                wr_data;
  logic                  clr_en;
  logic                  set_en;

  logic                  free_found;
  logic [IdxW-1:0]       free_idx;

  logic [31:0]           age;
  logic                  expired;
  logic                  hit;

  logic                  ev_vld;
  logic [2:0]            ev_kind;
  logic [31:0]           ev_rid;
  logic [7:0]            ev_trap;
  logic [31:0]           ev_ip;

  logic                  pend_vld_q;
  logic [2:0]            pend_kind_q;
  logic [31:0]           pend_rid_q;
  logic [7:0]            pend_trap_q;
  logic [31:0]           pend_ip_q;

  logic                  res_vld_q;
  logic [2:0]            res_kind_q;
  logic [31:0]           res_rid_q;
  logic [7:0]            res_trap_q;
  logic [31:0]           res_ip_q;
  logic                  res_last_q;

  assign status_o.scan_needed = (req_type_i != ReqAdd) || (build_ok_i && replace_queued_i);
  assign status_o.scan_end    = (scan_idx_q == IdxW'(TableDepth - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q     <= req_type_i;
      rid_q      <= request_id_i;
      trap_q     <= trap_handle_i;
      ip_q       <= dest_ip_i;
      build_ok_q <= build_ok_i;
      inform_q   <= is_inform_i;
      retries_q  <= retry_count_i;
      timeout_q  <= timeout_ms_i;
      now_q      <= now_ms_i;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign age     = now_q - rd_data_q.last_sent;
  assign expired = age > {8'd0, rd_data_q.timeout};

  always_comb begin
    ev_vld  = 1'b0;
    ev_kind = KindDone;
    ev_rid  = rd_data_q.request_id;
    ev_trap = rd_data_q.trap;
    ev_ip   = rd_data_q.ip;
    wr_en   = 1'b0;
    wr_idx  = rd_idx_q;
    wr_data = rd_data_q;
    clr_en  = 1'b0;
    set_en  = 1'b0;
    hit     = 1'b0;
    if (rd_vld_q && valid_q[rd_idx_q]) begin
      case (type_q)
        ReqAck:  hit = (rd_data_q.request_id == rid_q);
        ReqTick: hit = expired;
        default: hit = (rd_data_q.trap == trap_q);
      endcase
      if (hit) begin
        ev_vld = 1'b1;
        if (type_q == ReqTick && rd_data_q.retries != 8'd0) begin
          ev_kind           = KindResend;
          wr_en             = 1'b1;
          wr_data.last_sent = now_q;
          wr_data.retries   = rd_data_q.retries - 8'd1;
        end else begin
          ev_kind = KindRetire;
          clr_en  = 1'b1;
        end
      end
    end else if (cmd_i.final_step && type_q == ReqAdd) begin
      ev_vld  = 1'b1;
      ev_rid  = rid_q;
      ev_trap = trap_q;
      ev_ip   = ip_q;
      if (!build_ok_q || (inform_q && !free_found)) begin
        ev_kind = KindReject;
        ev_trap = '0;
        ev_ip   = '0;
      end else if (inform_q) begin
        ev_kind = KindInform;
        wr_en   = 1'b1;
        set_en  = 1'b1;
        wr_idx  = free_idx;
        wr_data = '{request_id: rid_q, trap: trap_q, ip: ip_q, retries: retries_q,
                    timeout: timeout_q, last_sent: now_q};
      end else begin
        ev_kind = KindPlain;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem[scan_idx_q];
      rd_idx_q  <= scan_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + IdxW'(1);
      end
      if (clr_en) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (set_en) begin
        valid_q[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      if (ev_vld) begin
        pend_vld_q <= 1'b1;
        res_vld_q  <= pend_vld_q;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
        res_vld_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_vld) begin
      pend_kind_q <= ev_kind;
      pend_rid_q  <= ev_rid;
      pend_trap_q <= ev_trap;
      pend_ip_q   <= ev_ip;
      res_kind_q  <= pend_kind_q;
      res_rid_q   <= pend_rid_q;
      res_trap_q  <= pend_trap_q;
      res_ip_q    <= pend_ip_q;
      res_last_q  <= 1'b0;
    end else if (cmd_i.flush) begin
      res_last_q <= 1'b1;
      if (pend_vld_q) begin
        res_kind_q <= pend_kind_q;
        res_rid_q  <= pend_rid_q;
        res_trap_q <= pend_trap_q;
        res_ip_q   <= pend_ip_q;
      end else begin
        res_kind_q <= KindDone;
        res_rid_q  <= '0;
        res_trap_q <= '0;
        res_ip_q   <= '0;
      end
    end
  end

  assign result_valid_o    = res_vld_q;
  assign result_kind_o     = res_kind_q;
  assign out_request_id_o  = res_rid_q;
  assign out_trap_handle_o = res_trap_q;
  assign out_ip_o          = res_ip_q;
  assign last_o            = res_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> res_vld_q && res_last_q)
    else $error("flush did not present a final item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !cmd_i.final_step)
    else $error("final step overlaps scan pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_en |=> valid_q[$past(free_idx)])
    else $error("inserted entry not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !pend_vld_q)
    else $error("stale pending item at accept");

endmodule

// ===== rtl/core/inform_retry_table.sv =====
// ----------------------------------------------------------------------------
// inform_retry_table
// Table of pending informs with acknowledge, cancel and timeout resend.
// ----------------------------------------------------------------------------
// Sequence: a scanning item (acknowledge, cancel, tick, add with replace) keeps
//   busy high through one table read per entry, then drain, final and flush;
//   an add without replace or a failed add keeps it high through final and
//   flush.
// Items: a new item is accepted only once busy is low again.
// Results appear one per strobe cycle, the last one in the first cycle with busy low.
// Reset: rst_ni clears all entry valid bits and the sequencer at once.
// ----------------------------------------------------------------------------
module inform_retry_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] request_id_i,
  input  logic [7:0]  trap_handle_i,
  input  logic [31:0] dest_ip_i,
  input  logic        build_ok_i,
  input  logic        is_inform_i,
  input  logic        replace_queued_i,
  input  logic [7:0]  retry_count_i,
  input  logic [23:0] timeout_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        result_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [31:0] out_request_id_o,
  output logic [7:0]  out_trap_handle_o,
  output logic [31:0] out_ip_o,
  output logic        last_o
);
  import irt_pkg::*;

  irt_cmd_t    cmd;
  irt_status_t status;

  irt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  irt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (req_type_i),
    .request_id_i      (request_id_i),
    .trap_handle_i     (trap_handle_i),
    .dest_ip_i         (dest_ip_i),
    .build_ok_i        (build_ok_i),
    .is_inform_i       (is_inform_i),
    .replace_queued_i  (replace_queued_i),
    .retry_count_i     (retry_count_i),
    .timeout_ms_i      (timeout_ms_i),
    .now_ms_i          (now_ms_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .out_request_id_o  (out_request_id_o),
    .out_trap_handle_o (out_trap_handle_o),
    .out_ip_o          (out_ip_o),
    .last_o            (last_o)
  );

endmodule
